### rtl/core/mer_pkg.sv
// ----------------------------------------------------------------------------
// mer_pkg
// Shared constants for the midpoint ellipse rasterizer: default widths and
// the command codes of the input item.
// ----------------------------------------------------------------------------
package mer_pkg;

  localparam int RADIUS_BITS_DEF = 10;
  localparam int COORD_BITS_DEF  = 12;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

endpackage

### rtl/core/mer_mul.sv
// ----------------------------------------------------------------------------
// mer_mul
// Shared unsigned multiplier with a registered product. The sequencer feeds
// one operand pair per cycle and reads the product in the next cycle.
// ----------------------------------------------------------------------------
module mer_mul
  import mer_pkg::*;
#(
  parameter int A_W = 2 * RADIUS_BITS_DEF,
  parameter int B_W = 2 * RADIUS_BITS_DEF + 6
) (
  input  logic                 clk,
  input  logic [A_W-1:0]       a,
  input  logic [B_W-1:0]       b,
  output logic [A_W+B_W-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= (A_W + B_W)'(a) * (A_W + B_W)'(b);
  end

endmodule

### rtl/core/midpoint_ellipse_rasterizer_core.sv
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_core
// Midpoint ellipse walk: a start item loads the geometry and plots the first
// four mirrored pixels, each advance item during an active walk plots the next four.
// ----------------------------------------------------------------------------
//   channel  handshake            payload
//   in       in_valid / in_ready  command, radius_x, radius_y, centre_x, centre_y
//   out      out_valid / out_ready pixel_x, pixel_y, last_pixel
//
// A start item runs setup states ST0 to ST3 and CHK (three products on the
// shared multiplier and a region check), EMIT for four pixels and update
// states UPD1, UPD2 and CHK, plus entry states E0 to E5 whenever the walk
// enters region 2. An advance item runs EMIT and the update states, plus E0
// to E5 on entry to region 2; the one multiplier sets the length of the setup
// and region 2 entry sequences. EMIT waits while out_ready is low. An advance
// while idle is taken and plots nothing. Reset returns the block to idle.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_core
  import mer_pkg::*;
#(
  parameter int RADIUS_BITS = RADIUS_BITS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          command,
  input  logic [RADIUS_BITS-1:0]        radius_x,
  input  logic [RADIUS_BITS-1:0]        radius_y,
  input  logic signed [COORD_BITS-1:0]  centre_x,
  input  logic signed [COORD_BITS-1:0]  centre_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_BITS:0]    pixel_x,
  output logic signed [COORD_BITS:0]    pixel_y,
  output logic                          last_pixel
);

  localparam int R2_W    = 2 * RADIUS_BITS;
  localparam int OFF_W   = RADIUS_BITS + 2;
  localparam int SLOPE_W = 3 * RADIUS_BITS + 4;
  localparam int DEC_W   = 4 * RADIUS_BITS + 8;
  localparam int MA_W    = R2_W;
  localparam int MB_W    = 2 * RADIUS_BITS + 6;
  localparam int MP_W    = MA_W + MB_W;
  localparam int PIX_W   = COORD_BITS + 1;
  localparam int SUM_W   = ((COORD_BITS > OFF_W) ? COORD_BITS : OFF_W) + 1;

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_ST0  = 15'h0002,
    S_ST1  = 15'h0004,
    S_ST2  = 15'h0008,
    S_ST3  = 15'h0010,
    S_CHK  = 15'h0020,
    S_E0   = 15'h0040,
    S_E1   = 15'h0080,
    S_E2   = 15'h0100,
    S_E3   = 15'h0200,
    S_E4   = 15'h0400,
    S_E5   = 15'h0800,
    S_EMIT = 15'h1000,
    S_UPD1 = 15'h2000,
    S_UPD2 = 15'h4000
  } state_t;

  state_t state, state_next;

  logic                        active;
  logic                        in2;
  logic                        from_start;
  logic [1:0]                  k;
  logic                        inc_x, dec_y;
  logic                        inc_x_q, dec_y_q;

  logic [RADIUS_BITS-1:0]      held_rx, held_ry;
  logic signed [COORD_BITS-1:0] held_cx, held_cy;
  logic [R2_W-1:0]             rx2, ry2;
  logic signed [OFF_W-1:0]     x, y;
  logic signed [SLOPE_W-1:0]   sx, sy;
  logic [DEC_W-1:0]            d;
  logic [DEC_W-1:0]            addend;

  logic [MA_W-1:0]             mul_a;
  logic [MB_W-1:0]             mul_b;
  logic [MP_W-1:0]             p;
  logic [OFF_W-1:0]            tx;
  logic [OFF_W-1:0]            ym1abs;

  logic                        in_acc, out_acc;
  logic signed [SUM_W-1:0]     cx_e, cy_e, xs_e, ys_e;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  mer_mul #(.A_W(MA_W), .B_W(MB_W)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  // Region 2 entry operands: 2x+1, and |y-1| where y is never below zero here.
  assign tx     = {x[OFF_W-2:0], 1'b1};
  assign ym1abs = (y == '0) ? OFF_W'(1) : OFF_W'(y - OFF_W'(1));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_ST0: begin
        mul_a = MA_W'(held_rx);
        mul_b = MB_W'(held_rx);
      end
      S_ST1: begin
        mul_a = MA_W'(held_ry);
        mul_b = MB_W'(held_ry);
      end
      S_ST2: begin
        mul_a = rx2;
        mul_b = MB_W'(held_ry);
      end
      S_E0: begin
        mul_a = MA_W'(tx);
        mul_b = MB_W'(tx);
      end
      S_E1: begin
        mul_a = ry2;
        mul_b = p[MB_W-1:0];
      end
      S_E2: begin
        mul_a = MA_W'(ym1abs);
        mul_b = MB_W'(ym1abs);
      end
      S_E3: begin
        mul_a = rx2;
        mul_b = p[MB_W-1:0];
      end
      S_E4: begin
        mul_a = rx2;
        mul_b = MB_W'(ry2);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Step direction for this iteration, taken from the decision sign.
  always_comb begin
    if (in2) begin
      dec_y = 1'b1;
      inc_x = d[DEC_W-1] || (d == '0);
    end else begin
      inc_x = 1'b1;
      dec_y = !d[DEC_W-1];
    end
  end

  always_comb begin
    addend = (inc_x_q ? DEC_W'(sx) : '0) - (dec_y_q ? DEC_W'(sy) : '0)
           + (in2 ? DEC_W'(rx2) : DEC_W'(ry2));
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (command == CMD_START) begin
            state_next = S_ST0;
          end else if (active) begin
            state_next = S_EMIT;
          end
        end
      end
      S_ST0: state_next = S_ST1;
      S_ST1: state_next = S_ST2;
      S_ST2: state_next = S_ST3;
      S_ST3: state_next = S_CHK;
      S_CHK: begin
        if (!in2 && (sx >= sy)) begin
          state_next = S_E0;
        end else if (from_start) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_E0: state_next = S_E1;
      S_E1: state_next = S_E2;
      S_E2: state_next = S_E3;
      S_E3: state_next = S_E4;
      S_E4: state_next = S_E5;
      S_E5: state_next = from_start ? S_EMIT : S_IDLE;
      S_EMIT: begin
        if (out_ready && (k == 2'd3)) begin
          state_next = S_UPD1;
        end
      end
      S_UPD1: state_next = S_UPD2;
      S_UPD2: state_next = S_CHK;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      active     <= 1'b0;
      in2        <= 1'b0;
      from_start <= 1'b0;
      k          <= '0;
    end else begin
      state <= state_next;
      if (in_acc && (command == CMD_START)) begin
        active     <= 1'b1;
        in2        <= 1'b0;
        from_start <= 1'b1;
      end
      if (state == S_E5) begin
        in2 <= 1'b1;
      end
      if (state == S_EMIT) begin
        from_start <= 1'b0;
      end
      if (out_acc) begin
        k <= k + 2'd1;
      end
      // The walk ends once region 2 has stepped below the axis.
      if ((state == S_UPD2) && in2 && y[OFF_W-1]) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid && (command == CMD_START)) begin
          held_rx <= radius_x;
          held_ry <= radius_y;
          held_cx <= centre_x;
          held_cy <= centre_y;
          x       <= '0;
          y       <= OFF_W'(radius_y);
          sx      <= '0;
        end
      end
      S_ST1: rx2 <= p[R2_W-1:0];
      S_ST2: ry2 <= p[R2_W-1:0];
      S_ST3: begin
        sy <= {p[SLOPE_W-2:0], 1'b0};
        d  <= (DEC_W'(ry2) << 2) - (DEC_W'(p) << 2) + DEC_W'(rx2);
      end
      S_E2: d <= DEC_W'(p);
      S_E4: d <= d + (DEC_W'(p) << 2);
      S_E5: d <= d - (DEC_W'(p) << 2);
      S_UPD1: begin
        inc_x_q <= inc_x;
        dec_y_q <= dec_y;
        if (inc_x) begin
          x  <= x + OFF_W'(1);
          sx <= sx + SLOPE_W'({ry2, 1'b0});
        end
        if (dec_y) begin
          y  <= y - OFF_W'(1);
          sy <= sy - SLOPE_W'({rx2, 1'b0});
        end
      end
      S_UPD2: d <= d + (addend << 2);
      default: begin
      end
    endcase
  end

  // Mirror order: (+x,+y), (-x,+y), (+x,-y), (-x,-y).
  assign cx_e = SUM_W'(held_cx);
  assign cy_e = SUM_W'(held_cy);
  assign xs_e = SUM_W'(x);
  assign ys_e = SUM_W'(y);

  assign pixel_x    = PIX_W'(k[0] ? (cx_e - xs_e) : (cx_e + xs_e));
  assign pixel_y    = PIX_W'(k[1] ? (cy_e - ys_e) : (cy_e + ys_e));
  assign last_pixel = (k == 2'd3) && in2 && (y == '0);

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && in_ready))
    else $error("input and output sides active together");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_acc && last_pixel |-> ##3 !active)
    else $error("walk still active after final pixel");

  a_idle_advance: assert property (@(posedge clk) disable iff (rst)
    in_acc && (command == CMD_ADVANCE) && !active |=> in_ready)
    else $error("advance while idle started work");

  a_region_hold: assert property (@(posedge clk) disable iff (rst)
    $fell(in2) |-> $past(rst) || $past(in_acc && (command == CMD_START)))
    else $error("region 2 left without a start item");

  a_emit_above_axis: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !y[OFF_W-1])
    else $error("plotting with offset below the axis");
`endif

endmodule
